[rtl/packed_pixel_rect_copy_addresser_macros.svh]
// Assertion macros shared by the checker of the rectangle-copy addresser.
`ifndef PACKED_PIXEL_RECT_COPY_ADDRESSER_MACROS_SVH
`define PACKED_PIXEL_RECT_COPY_ADDRESSER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPRA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ppra check failed");

// The consequent must hold in the cycle after the antecedent.
`define PPRA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ppra check failed");

`endif

[rtl/ppra_pkg.sv]
// Types, codes and helper functions of the rectangle-copy addresser.
package ppra_pkg;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned DEPTH_W    = 3;
  localparam int unsigned STRIDE_W   = 16;
  localparam int unsigned BASE_W     = 32;
  localparam int unsigned IN_COORD_W = 16;
  localparam int unsigned OUT_ADDR_W = 32;
  localparam int unsigned SHIFT_W    = 3;
  localparam int unsigned MASK_W     = 32;

  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 3'd3;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEPTH      = 3'd0,
    REG_SRC_STRIDE = 3'd1,
    REG_DST_STRIDE = 3'd2,
    REG_SRC_BASE   = 3'd3,
    REG_DST_BASE   = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic row_end;
    logic last;
  } flags_t;

  // Log2 of the bits per pixel; the unused codes act as 32 bits per pixel.
  function automatic logic [2:0] depth_log2(input logic [DEPTH_W-1:0] code);
    logic [2:0] res;
    if (code > 3'd5) begin
      res = 3'd5;
    end else begin
      res = code;
    end
    return res;
  endfunction

  function automatic logic [MASK_W-1:0] depth_mask(input logic [DEPTH_W-1:0] code);
    logic [MASK_W-1:0] res;
    unique case (depth_log2(code))
      3'd0:    res = 32'h1;
      3'd1:    res = 32'h3;
      3'd2:    res = 32'hf;
      3'd3:    res = 32'hff;
      3'd4:    res = 32'hffff;
      default: res = 32'hffff_ffff;
    endcase
    return res;
  endfunction

endpackage

[rtl/ppra_front.sv]
// Front end: takes items, tracks the rectangle walk and issues pixel commands.
module ppra_front import ppra_pkg::*; #(
  parameter int unsigned ADDR_WIDTH  = 32,
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic                    operation_i,
  input  logic [IN_COORD_W-1:0]   dest_col_i,
  input  logic [IN_COORD_W-1:0]   dest_row_i,
  input  logic [IN_COORD_W-1:0]   source_col_i,
  input  logic [IN_COORD_W-1:0]   source_row_i,
  input  logic [IN_COORD_W-1:0]   width_pixels_i,
  input  logic [IN_COORD_W-1:0]   height_rows_i,
  input  logic [STRIDE_W-1:0]     src_stride_i,
  input  logic [STRIDE_W-1:0]     dst_stride_i,
  output logic                    cmd_valid_o,
  output logic [ADDR_WIDTH-1:0]   cmd_src_off_o,
  output logic [ADDR_WIDTH-1:0]   cmd_dst_off_o,
  output logic [COORD_WIDTH:0]    cmd_scol_o,
  output logic [COORD_WIDTH:0]    cmd_dcol_o,
  output flags_t                  cmd_flags_o
);

  localparam int unsigned CW    = COORD_WIDTH;
  localparam int unsigned COLW  = CW + 1;
  localparam int unsigned PRODW = CW + STRIDE_W;
  localparam int unsigned MULW  = (ADDR_WIDTH > PRODW) ? ADDR_WIDTH : PRODW;

  logic                  busy_q, busy_d;
  logic [ADDR_WIDTH-1:0] src_off_q, src_off_d, dst_off_q, dst_off_d;
  logic [CW-1:0]         col_idx_q, col_idx_d, rows_left_q, rows_left_d;
  logic [CW-1:0]         saved_scol_q, saved_scol_d, saved_dcol_q, saved_dcol_d;
  logic [CW-1:0]         width_q, width_d;
  logic [COLW-1:0]       scol_q, scol_d, dcol_q, dcol_d;

  logic [CW-1:0]    srow, drow, height, scol_in, dcol_in, width_in;
  logic [PRODW-1:0] src_prod, dst_prod;
  logic [MULW-1:0]  src_prod_w, dst_prod_w;
  logic [COLW-1:0]  col_next;
  logic             row_end, last;

  assign srow     = CW'(source_row_i);
  assign drow     = CW'(dest_row_i);
  assign height   = CW'(height_rows_i);
  assign scol_in  = CW'(source_col_i);
  assign dcol_in  = CW'(dest_col_i);
  assign width_in = CW'(width_pixels_i);

  assign src_prod   = PRODW'(srow) * PRODW'(src_stride_i);
  assign dst_prod   = PRODW'(drow) * PRODW'(dst_stride_i);
  assign src_prod_w = MULW'(src_prod);
  assign dst_prod_w = MULW'(dst_prod);

  assign col_next = {1'b0, col_idx_q} + COLW'(1);
  assign row_end  = col_next >= {1'b0, width_q};
  assign last     = row_end && (rows_left_q <= CW'(1));

  assign cmd_src_off_o       = src_off_q;
  assign cmd_dst_off_o       = dst_off_q;
  assign cmd_scol_o          = scol_q;
  assign cmd_dcol_o          = dcol_q;
  assign cmd_flags_o.row_end = row_end;
  assign cmd_flags_o.last    = last;

  always_comb begin
    busy_d       = busy_q;
    src_off_d    = src_off_q;
    dst_off_d    = dst_off_q;
    col_idx_d    = col_idx_q;
    rows_left_d  = rows_left_q;
    saved_scol_d = saved_scol_q;
    saved_dcol_d = saved_dcol_q;
    width_d      = width_q;
    scol_d       = scol_q;
    dcol_d       = dcol_q;
    cmd_valid_o  = 1'b0;
    if (accept_i) begin
      if (op_e'(operation_i) == OP_START) begin
        saved_scol_d = scol_in;
        saved_dcol_d = dcol_in;
        width_d      = width_in;
        src_off_d    = src_prod_w[ADDR_WIDTH-1:0];
        dst_off_d    = dst_prod_w[ADDR_WIDTH-1:0];
        col_idx_d    = '0;
        rows_left_d  = height;
        scol_d       = {1'b0, scol_in};
        dcol_d       = {1'b0, dcol_in};
        busy_d       = (width_in != '0) && (height != '0);
      end else if (busy_q) begin
        cmd_valid_o = 1'b1;
        if (row_end) begin
          col_idx_d   = '0;
          rows_left_d = rows_left_q - CW'(1);
          src_off_d   = src_off_q + ADDR_WIDTH'(src_stride_i);
          dst_off_d   = dst_off_q + ADDR_WIDTH'(dst_stride_i);
          scol_d      = {1'b0, saved_scol_q};
          dcol_d      = {1'b0, saved_dcol_q};
          if (last) begin
            busy_d = 1'b0;
          end
        end else begin
          col_idx_d = col_next[CW-1:0];
          scol_d    = scol_q + COLW'(1);
          dcol_d    = dcol_q + COLW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      col_idx_q   <= '0;
      rows_left_q <= '0;
    end else begin
      busy_q      <= busy_d;
      col_idx_q   <= col_idx_d;
      rows_left_q <= rows_left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_off_q    <= src_off_d;
    dst_off_q    <= dst_off_d;
    saved_scol_q <= saved_scol_d;
    saved_dcol_q <= saved_dcol_d;
    width_q      <= width_d;
    scol_q       <= scol_d;
    dcol_q       <= dcol_d;
  end

endmodule

[rtl/ppra_queue.sv]
// Two-entry queue of pixel commands between the front and back ends.
module ppra_queue import ppra_pkg::*; #(
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic [DATA_W-1:0] rdata_o,
  output logic              empty_o
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = count_q == CNT_W'(DEPTH);
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

[rtl/ppra_back.sv]
// Back end: turns pixel commands into byte addresses, shifts and masks.
module ppra_back import ppra_pkg::*; #(
  parameter int unsigned ADDR_WIDTH  = 32,
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  output logic                  cmd_pop_o,
  input  logic [ADDR_WIDTH-1:0] cmd_src_off_i,
  input  logic [ADDR_WIDTH-1:0] cmd_dst_off_i,
  input  logic [COORD_WIDTH:0]  cmd_scol_i,
  input  logic [COORD_WIDTH:0]  cmd_dcol_i,
  input  flags_t                cmd_flags_i,
  input  logic [DEPTH_W-1:0]    depth_code_i,
  input  logic [BASE_W-1:0]     src_base_i,
  input  logic [BASE_W-1:0]     dst_base_i,
  output logic                  empty_o,
  input  logic                  pop_i,
  output logic [OUT_ADDR_W-1:0] source_addr_o,
  output logic [SHIFT_W-1:0]    source_shift_o,
  output logic [OUT_ADDR_W-1:0] dest_addr_o,
  output logic [SHIFT_W-1:0]    dest_shift_o,
  output logic [MASK_W-1:0]     pixel_mask_o,
  output logic                  row_end_o,
  output logic                  last_o
);

  localparam int unsigned BITW  = COORD_WIDTH + 6;
  localparam int unsigned BYTEW = BITW - 3;
  localparam int unsigned SUMW  = (ADDR_WIDTH > BYTEW) ? ADDR_WIDTH : BYTEW;
  localparam int unsigned OUTW  = (ADDR_WIDTH > OUT_ADDR_W) ? ADDR_WIDTH : OUT_ADDR_W;

  logic                  s1_ready, s2_ready;
  logic                  s1_valid_q, s1_valid_d, s2_valid_q, s2_valid_d;
  logic [ADDR_WIDTH-1:0] s1_src_row_q, s1_dst_row_q;
  logic [BYTEW-1:0]      s1_src_byte_q, s1_dst_byte_q;
  logic [SHIFT_W-1:0]    s1_src_shift_q, s1_dst_shift_q, s2_src_shift_q, s2_dst_shift_q;
  logic [MASK_W-1:0]     s1_mask_q, s2_mask_q;
  flags_t                s1_flags_q, s2_flags_q;
  logic [ADDR_WIDTH-1:0] s2_src_addr_q, s2_dst_addr_q;

  logic [BITW-1:0]       src_bit, dst_bit;
  logic [SUMW-1:0]       src_byte_w, dst_byte_w;
  logic [OUTW-1:0]       src_out_w, dst_out_w;

  assign s2_ready   = !s2_valid_q || pop_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign cmd_pop_o  = cmd_valid_i && s1_ready;
  assign s1_valid_d = s1_ready ? cmd_valid_i : s1_valid_q;
  assign s2_valid_d = s2_ready ? s1_valid_q : s2_valid_q;

  assign src_bit = BITW'(cmd_scol_i) << depth_log2(depth_code_i);
  assign dst_bit = BITW'(cmd_dcol_i) << depth_log2(depth_code_i);

  assign src_byte_w = SUMW'(s1_src_byte_q);
  assign dst_byte_w = SUMW'(s1_dst_byte_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      s1_src_row_q   <= ADDR_WIDTH'(src_base_i) + cmd_src_off_i;
      s1_dst_row_q   <= ADDR_WIDTH'(dst_base_i) + cmd_dst_off_i;
      s1_src_byte_q  <= src_bit[BITW-1:3];
      s1_dst_byte_q  <= dst_bit[BITW-1:3];
      s1_src_shift_q <= src_bit[2:0];
      s1_dst_shift_q <= dst_bit[2:0];
      s1_mask_q      <= depth_mask(depth_code_i);
      s1_flags_q     <= cmd_flags_i;
    end
    if (s2_ready && s1_valid_q) begin
      s2_src_addr_q  <= s1_src_row_q + src_byte_w[ADDR_WIDTH-1:0];
      s2_dst_addr_q  <= s1_dst_row_q + dst_byte_w[ADDR_WIDTH-1:0];
      s2_src_shift_q <= s1_src_shift_q;
      s2_dst_shift_q <= s1_dst_shift_q;
      s2_mask_q      <= s1_mask_q;
      s2_flags_q     <= s1_flags_q;
    end
  end

  assign src_out_w = OUTW'(s2_src_addr_q);
  assign dst_out_w = OUTW'(s2_dst_addr_q);

  assign empty_o        = !s2_valid_q;
  assign source_addr_o  = src_out_w[OUT_ADDR_W-1:0];
  assign dest_addr_o    = dst_out_w[OUT_ADDR_W-1:0];
  assign source_shift_o = s2_src_shift_q;
  assign dest_shift_o   = s2_dst_shift_q;
  assign pixel_mask_o   = s2_mask_q;
  assign row_end_o      = s2_flags_q.row_end;
  assign last_o         = s2_flags_q.last;

endmodule

[rtl/packed_pixel_rect_copy_addresser.sv]
// Top level of the rectangle-copy address generator for packed framebuffers.
// A start item sets up a rectangle and yields nothing; each following step
// item yields the source and destination byte addresses, bit shifts and mask
// of one pixel, row by row, until the last pixel is flagged. One item is
// taken every clock cycle while full is low, and one result can leave
// every cycle; the front end's column and row counters advance once per
// step item taken. A step item is pushed into a two-entry command queue
// and passes through a two-stage address pipeline before its result
// appears on the outputs. Full rises only when results are not being
// popped and the queue and pipeline have filled.
module packed_pixel_rect_copy_addresser import ppra_pkg::*; #(
  parameter int unsigned ADDR_WIDTH  = 32,
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  push,
  output logic                  full,
  input  logic                  operation_i,
  input  logic [IN_COORD_W-1:0] dest_col_i,
  input  logic [IN_COORD_W-1:0] dest_row_i,
  input  logic [IN_COORD_W-1:0] source_col_i,
  input  logic [IN_COORD_W-1:0] source_row_i,
  input  logic [IN_COORD_W-1:0] width_pixels_i,
  input  logic [IN_COORD_W-1:0] height_rows_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [OUT_ADDR_W-1:0] source_addr_o,
  output logic [SHIFT_W-1:0]    source_shift_o,
  output logic [OUT_ADDR_W-1:0] dest_addr_o,
  output logic [SHIFT_W-1:0]    dest_shift_o,
  output logic [MASK_W-1:0]     pixel_mask_o,
  output logic                  row_end_o,
  output logic                  last_o
);

  localparam int unsigned COLW   = COORD_WIDTH + 1;
  localparam int unsigned DATA_W = 2 * ADDR_WIDTH + 2 * COLW + $bits(flags_t);

  logic [DEPTH_W-1:0]  depth_q;
  logic [STRIDE_W-1:0] src_stride_q, dst_stride_q;
  logic [BASE_W-1:0]   src_base_q, dst_base_q;

  logic                  accept;
  logic                  cmd_valid, q_empty, q_pop;
  logic [ADDR_WIDTH-1:0] f_src_off, f_dst_off, b_src_off, b_dst_off;
  logic [COLW-1:0]       f_scol, f_dcol, b_scol, b_dcol;
  flags_t                f_flags, b_flags;
  logic [DATA_W-1:0]     q_wdata, q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q      <= DEPTH_RESET;
      src_stride_q <= '0;
      dst_stride_q <= '0;
      src_base_q   <= '0;
      dst_base_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_DEPTH:      depth_q      <= cfg_data_i[DEPTH_W-1:0];
        REG_SRC_STRIDE: src_stride_q <= cfg_data_i[STRIDE_W-1:0];
        REG_DST_STRIDE: dst_stride_q <= cfg_data_i[STRIDE_W-1:0];
        REG_SRC_BASE:   src_base_q   <= cfg_data_i[BASE_W-1:0];
        REG_DST_BASE:   dst_base_q   <= cfg_data_i[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept = push && !full;

  ppra_front #(
    .ADDR_WIDTH (ADDR_WIDTH),
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .operation_i   (operation_i),
    .dest_col_i    (dest_col_i),
    .dest_row_i    (dest_row_i),
    .source_col_i  (source_col_i),
    .source_row_i  (source_row_i),
    .width_pixels_i(width_pixels_i),
    .height_rows_i (height_rows_i),
    .src_stride_i  (src_stride_q),
    .dst_stride_i  (dst_stride_q),
    .cmd_valid_o   (cmd_valid),
    .cmd_src_off_o (f_src_off),
    .cmd_dst_off_o (f_dst_off),
    .cmd_scol_o    (f_scol),
    .cmd_dcol_o    (f_dcol),
    .cmd_flags_o   (f_flags)
  );

  assign q_wdata = {f_src_off, f_dst_off, f_scol, f_dcol, f_flags};
  assign {b_src_off, b_dst_off, b_scol, b_dcol, b_flags} = q_rdata;

  ppra_queue #(
    .DATA_W(DATA_W)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_valid),
    .wdata_i(q_wdata),
    .full_o (full),
    .pop_i  (q_pop),
    .rdata_o(q_rdata),
    .empty_o(q_empty)
  );

  ppra_back #(
    .ADDR_WIDTH (ADDR_WIDTH),
    .COORD_WIDTH(COORD_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (!q_empty),
    .cmd_pop_o     (q_pop),
    .cmd_src_off_i (b_src_off),
    .cmd_dst_off_i (b_dst_off),
    .cmd_scol_i    (b_scol),
    .cmd_dcol_i    (b_dcol),
    .cmd_flags_i   (b_flags),
    .depth_code_i  (depth_q),
    .src_base_i    (src_base_q),
    .dst_base_i    (dst_base_q),
    .empty_o       (empty),
    .pop_i         (pop),
    .source_addr_o (source_addr_o),
    .source_shift_o(source_shift_o),
    .dest_addr_o   (dest_addr_o),
    .dest_shift_o  (dest_shift_o),
    .pixel_mask_o  (pixel_mask_o),
    .row_end_o     (row_end_o),
    .last_o        (last_o)
  );

endmodule

[rtl/ppra_checker.sv]
// Port-level checker of the rectangle-copy addresser and its bind statement.
`include "packed_pixel_rect_copy_addresser_macros.svh"

module ppra_checker import ppra_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  empty,
  input logic                  pop,
  input logic [OUT_ADDR_W-1:0] source_addr_o,
  input logic [SHIFT_W-1:0]    source_shift_o,
  input logic [OUT_ADDR_W-1:0] dest_addr_o,
  input logic [SHIFT_W-1:0]    dest_shift_o,
  input logic [MASK_W-1:0]     pixel_mask_o,
  input logic                  row_end_o,
  input logic                  last_o
);

  `PPRA_ASSERT_NEXT(held_item_a, !empty && !pop, !empty && $stable(source_addr_o) && $stable(dest_addr_o) && $stable(last_o))
  `PPRA_ASSERT_NOW(mask_form_a, !empty, pixel_mask_o == 32'h1 || pixel_mask_o == 32'h3 || pixel_mask_o == 32'hf || pixel_mask_o == 32'hff || pixel_mask_o == 32'hffff || pixel_mask_o == 32'hffff_ffff)
  `PPRA_ASSERT_NOW(byte_depth_shift_a, !empty && pixel_mask_o[7], source_shift_o == 3'd0 && dest_shift_o == 3'd0)
  `PPRA_ASSERT_NOW(last_ends_row_a, !empty && last_o, row_end_o)

endmodule

bind packed_pixel_rect_copy_addresser ppra_checker u_checker (.*);
